>>> rtl/irdl_pkg.sv
// ----------------------------------------------------------------------------
// irdl_pkg
// Shared types, calibration tables and constants of the IR distance
// linearizer.
// ----------------------------------------------------------------------------
package irdl_pkg;

  localparam int LANES       = 4;
  localparam int SAMPLE_W    = 12;                    // width of one ADC sample port
  localparam int SAMPLE_BITS = 12;                    // significant bits of a sample
  localparam int DIST_W      = 6;                     // width of one distance port
  localparam int TABLE_CAP   = 16;                    // entries in each table
  localparam int TBL_IDX_W   = 4;                     // index width of a table
  localparam int DIV_W       = 10;                    // width of a segment divisor
  localparam int PROD_W      = SAMPLE_W + 3;          // 5 * (point - sample)
  localparam int QUOT_BITS   = 3;                     // interpolation term, at most 5
  localparam int DSUM_W      = 7;                     // distance before masking
  localparam int BASE_CM     = 10;
  localparam int STEP_CM     = 5;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [DIST_W-1:0]    dist_t;
  typedef logic [TBL_IDX_W-1:0] idx_t;
  typedef logic [DIV_W-1:0]     div_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [QUOT_BITS-1:0] quot_t;
  typedef logic [DSUM_W-1:0]    dsum_t;

  localparam sample_t SAMPLE_MASK = sample_t'((1 << SAMPLE_BITS) - 1);

  // Calibration points, descending, 5 cm apart starting at 10 cm.
  localparam sample_t CAL_POINTS [TABLE_CAP] = '{
    12'd2822, 12'd1979, 12'd1570, 12'd1282, 12'd1114, 12'd941, 12'd848, 12'd748,
    12'd675,  12'd0,    12'd0,    12'd0,    12'd0,    12'd0,   12'd0,   12'd0
  };

  // Divisor of each segment; zero beyond the calibrated range.
  localparam div_t SEG_DIVISOR [TABLE_CAP] = '{
    10'd843, 10'd409, 10'd289, 10'd167, 10'd173, 10'd93, 10'd100, 10'd73,
    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,  10'd0,   10'd0
  };

  // Load enables of the four pipeline stages, shared by all lanes.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } irdl_stage_en_t;

endpackage

>>> rtl/ir_distance_linearizer.sv
// ----------------------------------------------------------------------------
// ir_distance_linearizer
// Converts four infrared ADC samples per transfer into distances in cm.
// ----------------------------------------------------------------------------
// Each transfer carries four 12-bit samples; each lane places its sample in
// a descending calibration table and interpolates linearly inside the
// segment, giving 10 cm above the first point and 50 cm at or below the last
// one. The block takes one transfer per clock while in_ready_o is high and
// passes each through the four register stages of every lane: segment
// search, divisor lookup with numerator, a three-step restoring division,
// and the final sum in the output register. Stages hold independently, so
// a stalled output only fills empty stages behind it and new transfers keep
// coming in until the pipeline is full. Results leave in input order, one
// per input transfer.
module ir_distance_linearizer import irdl_pkg::*; #(
  parameter int TABLE_POINTS = 9
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sample_t sample_0_i,
  input  sample_t sample_1_i,
  input  sample_t sample_2_i,
  input  sample_t sample_3_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dist_t   distance_0_o,
  output dist_t   distance_1_o,
  output dist_t   distance_2_o,
  output dist_t   distance_3_o
);

  // Valid bit per stage; a stage loads when it is empty or its
  // successor frees it in the same cycle.
  logic           v1_q, v2_q, v3_q, v4_q;
  logic           rdy1, rdy2, rdy3, rdy4;
  irdl_stage_en_t stage_en;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;

  // Load payload only when a valid item moves in.
  assign stage_en.s1 = rdy1 && in_valid_i;
  assign stage_en.s2 = rdy2 && v1_q;
  assign stage_en.s3 = rdy3 && v2_q;
  assign stage_en.s4 = rdy4 && v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Lanes share the stage enables; each owns its sample and result port.
  sample_t lane_smp  [LANES];
  dist_t   lane_dist [LANES];

  assign lane_smp[0] = sample_0_i;
  assign lane_smp[1] = sample_1_i;
  assign lane_smp[2] = sample_2_i;
  assign lane_smp[3] = sample_3_i;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    irdl_lane #(
      .TABLE_POINTS(TABLE_POINTS)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (stage_en),
      .sample_i  (lane_smp[g]),
      .distance_o(lane_dist[g])
    );
  end

  assign distance_0_o = lane_dist[0];
  assign distance_1_o = lane_dist[1];
  assign distance_2_o = lane_dist[2];
  assign distance_3_o = lane_dist[3];

endmodule

>>> rtl/irdl_lane.sv
// ----------------------------------------------------------------------------
// irdl_lane
// Datapath of one sensor lane: segment search, numerator, short restoring
// division and output sum, one register stage each.
// ----------------------------------------------------------------------------
module irdl_lane import irdl_pkg::*; #(
  parameter int TABLE_POINTS = 9
) (
  input  logic           clk_i,
  input  irdl_stage_en_t en_i,
  input  sample_t        sample_i,
  output dist_t          distance_o
);

  localparam int SEG_W     = $clog2(TABLE_POINTS + 1);
  localparam int SAT_HI_CM = BASE_CM + STEP_CM * (TABLE_POINTS - 1);

  // Stage 1: count leading table points the sample is at or below
  sample_t          s1_smp_d, s1_smp_q;
  logic [SEG_W-1:0] s1_seg_d, s1_seg_q;

  always_comb begin
    s1_smp_d = sample_i & SAMPLE_MASK;
    s1_seg_d = SEG_W'(TABLE_POINTS);
    for (int i = TABLE_POINTS - 1; i >= 0; i--) begin
      if (s1_smp_d > CAL_POINTS[i]) s1_seg_d = SEG_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_smp_q <= s1_smp_d;
      s1_seg_q <= s1_seg_d;
    end
  end

  // Stage 2: look up the segment, form 5 * (point - sample)
  idx_t    s2_lo_d, s2_lo_q;
  sample_t s2_diff;
  prod_t   s2_prod_d, s2_prod_q;
  div_t    s2_div_d, s2_div_q;
  logic    s2_sat_lo_d, s2_sat_lo_q;
  logic    s2_sat_hi_d, s2_sat_hi_q;

  always_comb begin
    s2_lo_d     = TBL_IDX_W'(s1_seg_q - SEG_W'(1));
    s2_diff     = CAL_POINTS[s2_lo_d] - s1_smp_q;
    s2_prod_d   = (PROD_W'(s2_diff) << 2) + PROD_W'(s2_diff);
    s2_div_d    = SEG_DIVISOR[s2_lo_d];
    s2_sat_lo_d = (s1_seg_q == '0);
    s2_sat_hi_d = (s1_seg_q == SEG_W'(TABLE_POINTS));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_lo_q     <= s2_lo_d;
      s2_prod_q   <= s2_prod_d;
      s2_div_q    <= s2_div_d;
      s2_sat_lo_q <= s2_sat_lo_d;
      s2_sat_hi_q <= s2_sat_hi_d;
    end
  end

  // Stage 3: restoring division, one quotient bit per step
  prod_t s3_rem;
  prod_t s3_trial;
  quot_t s3_quot_d, s3_quot_q;
  idx_t  s3_lo_q;
  logic  s3_sat_lo_q, s3_sat_hi_q;

  always_comb begin
    s3_rem    = s2_prod_q;
    s3_quot_d = '0;
    for (int b = QUOT_BITS - 1; b >= 0; b--) begin
      s3_trial = PROD_W'(s2_div_q) << b;
      if (s3_rem >= s3_trial) begin
        s3_rem       = s3_rem - s3_trial;
        s3_quot_d[b] = 1'b1;
      end
    end
    // a zero divisor contributes no interpolation term
    if (s2_div_q == '0) s3_quot_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_quot_q   <= s3_quot_d;
      s3_lo_q     <= s2_lo_q;
      s3_sat_lo_q <= s2_sat_lo_q;
      s3_sat_hi_q <= s2_sat_hi_q;
    end
  end

  // Stage 4: base + 5 * segment + term, saturated at both ends
  dsum_t s4_sum;
  dist_t s4_dist_d, s4_dist_q;

  always_comb begin
    if (s3_sat_lo_q) begin
      s4_sum = DSUM_W'(BASE_CM);
    end else if (s3_sat_hi_q) begin
      s4_sum = DSUM_W'(SAT_HI_CM);
    end else begin
      s4_sum = DSUM_W'(BASE_CM) + (DSUM_W'(s3_lo_q) << 2) + DSUM_W'(s3_lo_q)
             + DSUM_W'(s3_quot_q);
    end
    s4_dist_d = s4_sum[DIST_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) s4_dist_q <= s4_dist_d;
  end

  assign distance_o = s4_dist_q;

endmodule

>>> rtl/irdl_checker.sv
// ----------------------------------------------------------------------------
// irdl_checker
// Port-level assertions for the IR distance linearizer, bound to the top.
// ----------------------------------------------------------------------------
module irdl_checker import irdl_pkg::*; #(
  parameter int TABLE_POINTS = 9
) (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_o,
  input sample_t sample_0_i,
  input sample_t sample_1_i,
  input sample_t sample_2_i,
  input sample_t sample_3_i,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input dist_t   distance_0_o,
  input dist_t   distance_1_o,
  input dist_t   distance_2_o,
  input dist_t   distance_3_o
);

  localparam int MAX_CM = BASE_CM + STEP_CM * (TABLE_POINTS - 1);
  localparam logic WIDE = (MAX_CM >= (1 << DIST_W));

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o
      && $stable(distance_0_o) && $stable(distance_1_o)
      && $stable(distance_2_o) && $stable(distance_3_o))
    else $error("result changed while stalled");

  // A free output side never blocks the input side.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled with output ready");

  // Every delivered distance lies in the calibrated range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> WIDE || (
      distance_0_o >= dist_t'(BASE_CM) && distance_0_o <= dist_t'(MAX_CM) &&
      distance_1_o >= dist_t'(BASE_CM) && distance_1_o <= dist_t'(MAX_CM) &&
      distance_2_o >= dist_t'(BASE_CM) && distance_2_o <= dist_t'(MAX_CM) &&
      distance_3_o >= dist_t'(BASE_CM) && distance_3_o <= dist_t'(MAX_CM)))
    else $error("distance out of range");

  // A near sample on lane 0 comes out as the minimum distance while the output stays ready.
  a_near_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && ((sample_0_i & SAMPLE_MASK) > CAL_POINTS[0]))
      ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o && distance_0_o == dist_t'(BASE_CM))
    else $error("near sample did not saturate");

endmodule

bind ir_distance_linearizer irdl_checker #(
  .TABLE_POINTS(TABLE_POINTS)
) u_irdl_checker (.*);
